[sv/hse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hse_pkg;

    localparam int MAX_ITEMS_DEF = 16;
    localparam int KEY_W         = 32;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

[sv/hse_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sorted row. A traveling key either settles here (slot reached
// its fill tag, or key is smaller than the held one, which is then passed on) or moves on to the next slot.
module hse_cell #(
    parameter int TAG_W = 4,
    parameter int IDX   = 0
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_vld,
    input  wire logic [TAG_W-1:0]                 i_tag,
    input  wire logic signed [hse_pkg::KEY_W-1:0] i_key,
    input  wire logic                             i_pop,
    input  wire logic signed [hse_pkg::KEY_W-1:0] i_nbr_key,
    output logic                                  o_vld,
    output logic [TAG_W-1:0]                      o_tag,
    output logic signed [hse_pkg::KEY_W-1:0]      o_key,
    output logic signed [hse_pkg::KEY_W-1:0]      o_held
);
    import hse_pkg::*;

    localparam logic [TAG_W-1:0] MY_TAG = TAG_W'(IDX);

    logic                    r_vld;
    logic [TAG_W-1:0]        r_tag;
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] r_held;
    logic                    w_fill;
    logic                    w_swap;

    assign w_fill = (i_tag == MY_TAG);
    assign w_swap = !w_fill && (i_key < r_held);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld && !w_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= i_tag;
        r_key <= w_swap ? r_held : i_key;
        if (i_pop) begin
            r_held <= i_nbr_key;
        end else if (i_vld && (w_fill || w_swap)) begin
            r_held <= i_key;
        end
    end

    assign o_vld  = r_vld;
    assign o_tag  = r_tag;
    assign o_key  = r_key;
    assign o_held = r_held;

endmodule

`default_nettype wire

[sv/heap_sort_engine_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Loading: one key per cycle; each key ripples through the cell row, one cell a cycle.
// After the last key the row settles (every key in flight reaches its slot), then the output
// register loads the row's smallest key and the row shifts out one result per cycle while
// i_out_stall is low, smallest key first.
// Input is stalled from the last key until the largest key moves to the output register.
// Reset (synchronous, active low) clears the FSM, count, drop flag and pipeline valids.
module heap_sort_engine_top #(
    parameter int MAX_ITEMS = hse_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic signed [hse_pkg::KEY_W-1:0] i_key_value,
    input  wire logic                             i_is_last,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [hse_pkg::KEY_W-1:0]      o_sorted_key,
    output logic                                  o_last_of_run,
    output logic                                  o_keys_dropped
);
    import hse_pkg::*;

    localparam int TAG_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    t_state                  r_state;
    t_state                  n_state;
    logic [CNT_W-1:0]        r_key_count;
    logic                    r_overflow;
    logic                    r_ins_vld;
    logic [TAG_W-1:0]        r_ins_tag;
    logic signed [KEY_W-1:0] r_ins_key;
    logic                    r_out_valid;
    logic signed [KEY_W-1:0] r_out_key;
    logic                    r_out_last;
    logic                    r_out_drop;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_pop;
    logic                    w_busy;

    logic                    lnk_vld  [MAX_ITEMS+1];
    logic [TAG_W-1:0]        lnk_tag  [MAX_ITEMS+1];
    logic signed [KEY_W-1:0] lnk_key  [MAX_ITEMS+1];
    logic signed [KEY_W-1:0] held_key [MAX_ITEMS+1];
    logic [MAX_ITEMS:0]      lnk_busy;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_full   = (r_key_count >= CNT_MAX);

    assign lnk_vld[0]         = r_ins_vld;
    assign lnk_tag[0]         = r_ins_tag;
    assign lnk_key[0]         = r_ins_key;
    assign held_key[MAX_ITEMS] = '0;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        hse_cell #(
            .TAG_W (TAG_W),
            .IDX   (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_vld     (lnk_vld[g]),
            .i_tag     (lnk_tag[g]),
            .i_key     (lnk_key[g]),
            .i_pop     (w_pop),
            .i_nbr_key (held_key[g+1]),
            .o_vld     (lnk_vld[g+1]),
            .o_tag     (lnk_tag[g+1]),
            .o_key     (lnk_key[g+1]),
            .o_held    (held_key[g])
        );
    end

    always_comb begin
        for (int i = 0; i <= MAX_ITEMS; i++) begin
            lnk_busy[i] = lnk_vld[i];
        end
    end
    assign w_busy = |lnk_busy;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_accept && i_is_last) begin
                    n_state = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                if (!w_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_pop && (r_key_count == CNT_ONE)) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_pop      = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
            end
            ST_SETTLE: begin
                o_in_stall = 1'b1;
            end
            ST_EMIT: begin
                w_pop = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_key_count <= '0;
            r_overflow  <= 1'b0;
            r_ins_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ins_vld <= w_accept && !w_full;
            if (w_accept) begin
                if (w_full) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_key_count <= r_key_count + CNT_ONE;
                end
            end else if (w_pop) begin
                r_key_count <= r_key_count - CNT_ONE;
                if (r_key_count == CNT_ONE) begin
                    r_overflow <= 1'b0;
                end
            end
            if (w_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // slot index of the new key is the fill count before this beat
        r_ins_tag <= r_key_count[TAG_W-1:0];
        r_ins_key <= i_key_value;
        if (w_pop) begin
            r_out_key  <= held_key[0];
            r_out_last <= (r_key_count == CNT_ONE);
            r_out_drop <= r_overflow;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sorted_key   = r_out_key;
    assign o_last_of_run  = r_out_last;
    assign o_keys_dropped = r_out_drop;

    a_emit_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (!w_busy && (r_key_count != '0)))
        else $error("shift-out started with keys still in flight or row empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_count <= CNT_MAX)
        else $error("fill count above capacity");

    a_ins_from_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_full |=> r_ins_vld && (r_state != ST_EMIT))
        else $error("accepted key not launched into the row");

endmodule

`default_nettype wire
